FILE: design/nsp_pkg.sv
// shared types and codes for the nearest speaker panner
// no dependencies; used by nsp_seq and nearest_speaker_panner
package nsp_pkg;

   // input item kinds
   localparam logic [1:0] KIND_POINT   = 2'd0;
   localparam logic [1:0] KIND_DIFFUSE = 2'd1;
   localparam logic [1:0] KIND_SAMPLE  = 2'd2;
   localparam logic [1:0] KIND_LOAD    = 2'd3;

   // per-speaker operations run through the pipeline
   localparam logic [1:0] OP_SEARCH  = 2'd0;
   localparam logic [1:0] OP_POINT   = 2'd1;
   localparam logic [1:0] OP_DIFFUSE = 2'd2;
   localparam logic [1:0] OP_SAMPLE  = 2'd3;

   // configuration register indexes
   localparam int         CSR_INDEX_W       = 1;
   localparam logic [0:0] CSR_SPEAKER_COUNT = 1'd0;
   localparam logic [0:0] CSR_RAMP_SHIFT    = 1'd1;

   // one pipeline slot: which speaker, which operation
   typedef struct packed {
      logic       valid;
      logic [1:0] op;
      logic [2:0] idx;
      logic       last;
   } ctl_type;

endpackage

FILE: design/nearest_speaker_panner.sv
// Nearest speaker panner. Input items on req_* (valid/stall): kind selects a
// point chunk start, a diffuse chunk start, a sample or a speaker load.
// Results on rsp_*: one transfer per active speaker for each sample item,
// speaker_out counting up from 0, last set on the final speaker.
// Configuration on csr_*: speaker_count (index 0), ramp_shift (index 1). The user
// must write them only while the block is idle; the block does not enforce it.
// Flow, with n active speakers: a speaker load is written straight into the
// direction store. A sample or a diffuse chunk start runs one pass over the n
// speakers, a point chunk start two (a search pass over the direction store,
// then a step pass over the gain store). Each pass issues one speaker per
// cycle through the gain store's single read port, held while rsp_stall holds
// the pipe, into the three-stage read / multiply / sum pipeline that drains
// between items; a sample's results are registered in speaker order.
// Reset clears the valid bits of both stores at once, so directions, gains
// and steps read as zero; no clearing pass. Registers reset to 8 and 6.
// While rsp_stall holds a valid result the whole pipeline holds, including
// the stores' read registers; nothing is lost, req_stall stays high until done.
// Depends on nsp_pkg, nsp_ram and nsp_seq.
module nearest_speaker_panner #(
   parameter int SPEAKERS       = 8,
   parameter int GAIN_FRAC_BITS = 22
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_kind,
   input  logic [2:0]                      req_speaker_index,
   input  logic signed [15:0]              req_pos_x,
   input  logic signed [15:0]              req_pos_y,
   input  logic signed [15:0]              req_pos_z,
   input  logic signed [15:0]              req_sample_w,
   input  logic signed [15:0]              req_sample_x,
   input  logic signed [15:0]              req_sample_y,
   input  logic signed [15:0]              req_sample_z,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [2:0]                      rsp_speaker_out,
   output logic signed [19:0]              rsp_contribution,
   output logic                            rsp_last,
   input  logic                            csr_wr_en,
   input  logic [nsp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [3:0]                      csr_wdata
);

   localparam int G      = GAIN_FRAC_BITS;
   localparam int GW     = G + 2;
   localparam int SW     = G + 3;
   localparam int PW     = GW + 16;
   localparam int ACW    = PW + 2;
   localparam int GM_W   = 4 * GW + 4 * SW;
   localparam int ADDR_W = (SPEAKERS > 1) ? $clog2(SPEAKERS) : 1;
   localparam int LIM    = (SPEAKERS < 8) ? SPEAKERS : 8;

   localparam longint OMNI_L = (701 * (longint'(1) << G) + 500) / 1000;
   localparam logic signed [SW-1:0] ONE_T  = SW'(longint'(1) << G);
   localparam logic signed [SW-1:0] OMNI_T = SW'(OMNI_L);
   localparam logic signed [SW:0]   G_HI   = (SW + 1)'((longint'(1) << (G + 1)) - 1);
   localparam logic signed [SW:0]   G_LO   = (SW + 1)'(-(longint'(1) << (G + 1)));
   localparam logic signed [ACW-1:0] C_HI  = ACW'(524287);
   localparam logic signed [ACW-1:0] C_LO  = ACW'(-524288);

   function automatic logic signed [GW-1:0] sat_gain(input logic signed [SW:0] v);
      if (v > G_HI) begin
         return G_HI[GW-1:0];
      end else if (v < G_LO) begin
         return G_LO[GW-1:0];
      end
      return v[GW-1:0];
   endfunction

   function automatic logic signed [SW-1:0] coord_t(input logic signed [15:0] c);
      return {{(SW - 16 - (G - 14)){c[15]}}, c, {(G - 14){1'b0}}};
   endfunction

   // configuration registers
   logic [3:0] count_ff;
   logic [3:0] shift_ff;
   logic [2:0] last_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 4'd8;
         shift_ff <= 4'd6;
      end else if (csr_wr_en) begin
         case (csr_index)
            nsp_pkg::CSR_SPEAKER_COUNT: count_ff <= csr_wdata;
            nsp_pkg::CSR_RAMP_SHIFT:    shift_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // active count clamped to 1..LIM, kept as the final index
   always_comb begin
      if (count_ff == 4'd0) begin
         last_idx = 3'd0;
      end else if (int'(count_ff) > LIM) begin
         last_idx = 3'(LIM - 1);
      end else begin
         last_idx = 3'(count_ff - 4'd1);
      end
   end

   // handshakes and sequencing
   logic             adv;
   logic             busy;
   logic             req_xfer;
   logic             start;
   logic [1:0]       start_op;
   logic             load_we;
   nsp_pkg::ctl_type issue, c1, c2, c3;
   logic             rsp_valid_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = busy;
   assign req_xfer  = req_valid && !req_stall;
   assign start     = req_xfer && (req_kind != nsp_pkg::KIND_LOAD);
   assign load_we   = req_xfer && (req_kind == nsp_pkg::KIND_LOAD) &&
                      (32'(req_speaker_index) < SPEAKERS);

   always_comb begin
      case (req_kind)
         nsp_pkg::KIND_POINT:   start_op = nsp_pkg::OP_SEARCH;
         nsp_pkg::KIND_DIFFUSE: start_op = nsp_pkg::OP_DIFFUSE;
         nsp_pkg::KIND_SAMPLE:  start_op = nsp_pkg::OP_SAMPLE;
         default:               start_op = nsp_pkg::OP_SAMPLE;
      endcase
   end

   nsp_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .start    (start),
      .start_op (start_op),
      .last_idx (last_idx),
      .busy     (busy),
      .issue    (issue),
      .c1       (c1),
      .c2       (c2),
      .c3       (c3)
   );

   // item fields held for the whole item
   logic signed [15:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic signed [15:0] smp_w_ff, smp_x_ff, smp_y_ff, smp_z_ff;
   logic               diffuse_ff;

   always_ff @(posedge clock) begin
      if (start) begin
         pos_x_ff <= req_pos_x;
         pos_y_ff <= req_pos_y;
         pos_z_ff <= req_pos_z;
         smp_w_ff <= req_sample_w;
         smp_x_ff <= req_sample_x;
         smp_y_ff <= req_sample_y;
         smp_z_ff <= req_sample_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         diffuse_ff <= 1'b0;
      end else if (req_xfer && req_kind == nsp_pkg::KIND_POINT) begin
         diffuse_ff <= 1'b0;
      end else if (req_xfer && req_kind == nsp_pkg::KIND_DIFFUSE) begin
         diffuse_ff <= 1'b1;
      end
   end

   // direction store and gain/step store
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [47:0]       dir_rd;
   logic [GM_W-1:0]   gm_rd;
   logic              gm_we;
   logic [GM_W-1:0]   gm_wr;

   assign rd_en   = issue.valid && adv;
   assign rd_addr = ADDR_W'(issue.idx);
   assign gm_we   = c1.valid && adv && (c1.op != nsp_pkg::OP_SEARCH);

   nsp_ram #(.WIDTH(48), .DEPTH(SPEAKERS)) u_dir_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (load_we),
      .wr_addr (ADDR_W'(req_speaker_index)),
      .wr_data ({req_pos_z, req_pos_y, req_pos_x}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (dir_rd)
   );

   nsp_ram #(.WIDTH(GM_W), .DEPTH(SPEAKERS)) u_gain_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (gm_we),
      .wr_addr (ADDR_W'(c1.idx)),
      .wr_data (gm_wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (gm_rd)
   );

   // entry fields
   logic signed [15:0]   dir_x, dir_y, dir_z;
   logic signed [GW-1:0] go_r, gx_r, gy_r, gz_r;
   logic signed [SW-1:0] so_r, sx_r, sy_r, sz_r;

   assign dir_x = dir_rd[15:0];
   assign dir_y = dir_rd[31:16];
   assign dir_z = dir_rd[47:32];
   assign go_r  = gm_rd[GW-1:0];
   assign gx_r  = gm_rd[2*GW-1:GW];
   assign gy_r  = gm_rd[3*GW-1:2*GW];
   assign gz_r  = gm_rd[4*GW-1:3*GW];
   assign so_r  = gm_rd[4*GW+SW-1:4*GW];
   assign sx_r  = gm_rd[4*GW+2*SW-1:4*GW+SW];
   assign sy_r  = gm_rd[4*GW+3*SW-1:4*GW+2*SW];
   assign sz_r  = gm_rd[4*GW+4*SW-1:4*GW+3*SW];

   // first stage: distance terms, ramp steps, gain advance and write-back
   logic [2:0]           best_idx_ff;
   logic signed [35:0]   best_d_ff;
   logic signed [16:0]   dx_in, dy_in, dz_in;
   logic signed [SW-1:0] diff_o, diff_x, diff_y, diff_z, tgt_o;
   logic signed [SW-1:0] st_o, st_x, st_y, st_z;
   logic signed [GW-1:0] ng_o, ng_x, ng_y, ng_z;

   always_comb begin
      dx_in  = 17'(pos_x_ff) - 17'(dir_x);
      dy_in  = 17'(pos_y_ff) - 17'(dir_y);
      dz_in  = 17'(pos_z_ff) - 17'(dir_z);
      if (c1.op == nsp_pkg::OP_POINT) begin
         tgt_o = (c1.idx == best_idx_ff) ? ONE_T : '0;
      end else begin
         tgt_o = OMNI_T;
      end
      diff_o = tgt_o - SW'(go_r);
      diff_x = coord_t(dir_x) - SW'(gx_r);
      diff_y = coord_t(dir_y) - SW'(gy_r);
      diff_z = coord_t(dir_z) - SW'(gz_r);
      st_o   = diff_o >>> shift_ff;
      st_x   = diff_x >>> shift_ff;
      st_y   = diff_y >>> shift_ff;
      st_z   = diff_z >>> shift_ff;
      ng_o   = sat_gain((SW + 1)'(go_r) + (SW + 1)'(so_r));
      if (diffuse_ff) begin
         ng_x = sat_gain((SW + 1)'(gx_r) + (SW + 1)'(sx_r));
         ng_y = sat_gain((SW + 1)'(gy_r) + (SW + 1)'(sy_r));
         ng_z = sat_gain((SW + 1)'(gz_r) + (SW + 1)'(sz_r));
      end else begin
         ng_x = gx_r;
         ng_y = gy_r;
         ng_z = gz_r;
      end
   end

   // write-back: the entry read for this slot, with one field group replaced
   always_comb begin
      case (c1.op)
         nsp_pkg::OP_POINT:   gm_wr = {sz_r, sy_r, sx_r, st_o, gz_r, gy_r, gx_r, go_r};
         nsp_pkg::OP_DIFFUSE: gm_wr = {st_z, st_y, st_x, st_o, gz_r, gy_r, gx_r, go_r};
         nsp_pkg::OP_SAMPLE:  gm_wr = {sz_r, sy_r, sx_r, so_r, ng_z, ng_y, ng_x, ng_o};
         default:             gm_wr = gm_rd;
      endcase
   end

   logic signed [16:0]   dx_ff, dy_ff, dz_ff;
   logic signed [GW-1:0] g_o_ff, g_x_ff, g_y_ff, g_z_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         dz_ff  <= dz_in;
         g_o_ff <= ng_o;
         g_x_ff <= ng_x;
         g_y_ff <= ng_y;
         g_z_ff <= ng_z;
      end
   end

   // second stage: squares and gain products
   logic signed [33:0]   sqx_ff, sqy_ff, sqz_ff;
   logic signed [PW-1:0] p_o_ff, p_x_ff, p_y_ff, p_z_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sqx_ff <= dx_ff * dx_ff;
         sqy_ff <= dy_ff * dy_ff;
         sqz_ff <= dz_ff * dz_ff;
         p_o_ff <= g_o_ff * smp_w_ff;
         p_x_ff <= g_x_ff * smp_x_ff;
         p_y_ff <= g_y_ff * smp_y_ff;
         p_z_ff <= g_z_ff * smp_z_ff;
      end
   end

   // third stage: distance compare, contribution sum and saturation
   logic signed [35:0]    dist_sum;
   logic signed [ACW-1:0] acc, acc_sh;
   logic signed [19:0]    contribution_in;

   always_comb begin
      dist_sum = 36'(sqx_ff) + 36'(sqy_ff) + 36'(sqz_ff);
      acc  = ACW'(p_o_ff);
      if (diffuse_ff) begin
         acc = acc + ACW'(p_x_ff) + ACW'(p_y_ff) + ACW'(p_z_ff);
      end
      acc_sh = acc >>> G;
      if (acc_sh > C_HI) begin
         contribution_in = C_HI[19:0];
      end else if (acc_sh < C_LO) begin
         contribution_in = C_LO[19:0];
      end else begin
         contribution_in = acc_sh[19:0];
      end
   end

   // nearest speaker so far, lowest index wins ties
   always_ff @(posedge clock) begin
      if (adv && c3.valid && c3.op == nsp_pkg::OP_SEARCH) begin
         if (c3.idx == 3'd0 || dist_sum < best_d_ff) begin
            best_idx_ff <= c3.idx;
            best_d_ff   <= dist_sum;
         end
      end
   end

   // output register
   logic [2:0]         rsp_speaker_out_ff;
   logic signed [19:0] rsp_contribution_ff;
   logic               rsp_last_ff;
   logic               rsp_load;

   assign rsp_load = adv && c3.valid && (c3.op == nsp_pkg::OP_SAMPLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= rsp_load;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_speaker_out_ff  <= c3.idx;
         rsp_contribution_ff <= contribution_in;
         rsp_last_ff         <= c3.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_speaker_out  = rsp_speaker_out_ff;
   assign rsp_contribution = rsp_contribution_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef ASSERT_OFF
   // a new item only enters once the previous one has left the pipeline
   a_accept_drained: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> !(c1.valid || c2.valid || c3.valid))
      else $error("item accepted with speakers still in flight");

   // the final transfer of a sample belongs to the last active speaker
   a_last_speaker: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last) |-> (rsp_speaker_out == last_idx))
      else $error("last flag on wrong speaker");

   // gain store is only written while an item is being worked
   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      gm_we |-> busy)
      else $error("gain store written while idle");
`endif

endmodule

FILE: design/nsp_ram.sv
// single-port-write, single-port-read synchronous store with per-entry valid bits
// an entry never written reads as zero; no package dependency
module nsp_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 8
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rd_data_ff;

   // storage write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // valid bits, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // registered read, unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/nsp_seq.sv
// sequencer: walks the active speakers once per pass and tracks pipeline slots
// uses nsp_pkg for operation codes and the slot struct
module nsp_seq (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             start,
   input  logic [1:0]       start_op,
   input  logic [2:0]       last_idx,
   output logic             busy,
   output nsp_pkg::ctl_type issue,
   output nsp_pkg::ctl_type c1,
   output nsp_pkg::ctl_type c2,
   output nsp_pkg::ctl_type c3
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [1:0]       op_ff, op_in;
   logic [2:0]       k_ff, k_in;
   nsp_pkg::ctl_type c1_ff, c2_ff, c3_ff;
   logic             empty;

   assign empty = !c1_ff.valid && !c2_ff.valid && !c3_ff.valid;

   // slot entering the read stage this cycle
   always_comb begin
      issue.valid = (state_ff == ST_ISSUE);
      issue.op    = op_ff;
      issue.idx   = k_ff;
      issue.last  = (k_ff == last_idx);
   end

   // pass control
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      k_in     = k_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_ISSUE;
               op_in    = start_op;
               k_in     = 3'd0;
            end
         end
         ST_ISSUE: begin
            if (adv) begin
               if (k_ff == last_idx) begin
                  state_in = ST_DRAIN;
               end else begin
                  k_in = k_ff + 3'd1;
               end
            end
         end
         ST_DRAIN: begin
            // the nearest speaker is known only once the search pass has left the pipe
            if (empty) begin
               if (op_ff == nsp_pkg::OP_SEARCH) begin
                  state_in = ST_ISSUE;
                  op_in    = nsp_pkg::OP_POINT;
                  k_in     = 3'd0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= nsp_pkg::OP_SEARCH;
         k_ff     <= 3'd0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         k_ff     <= k_in;
      end
   end

   // pipeline slot shift
   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
         c3_ff <= '0;
      end else if (adv) begin
         c1_ff <= issue;
         c2_ff <= c1_ff;
         c3_ff <= c2_ff;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign c1   = c1_ff;
   assign c2   = c2_ff;
   assign c3   = c3_ff;

endmodule

FILE: verif/nearest_speaker_panner_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for nearest_speaker_panner: directed and random items,
// a predicting scoreboard for the per-speaker contributions, random idling
// depends on nsp_pkg and nearest_speaker_panner
module nearest_speaker_panner_tb;

   localparam int SPK           = 8;
   localparam int GAIN_FRAC     = 22;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 300000;

   // one input item as driven on the req_ ports
   typedef struct {
      logic [1:0]         kind;
      logic [2:0]         speaker_index;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic signed [15:0] sample_w;
      logic signed [15:0] sample_x;
      logic signed [15:0] sample_y;
      logic signed [15:0] sample_z;
   } panner_req_type;

   // one expected rsp_ transfer
   typedef struct {
      logic [2:0]         speaker;
      logic signed [19:0] contribution;
      logic               last;
   } contribution_type;

   // panner state mirror and queue of expected contributions
   class contribution_scoreboard_type;
      longint dir_x[SPK], dir_y[SPK], dir_z[SPK];
      longint gain_w[SPK], gain_x[SPK], gain_y[SPK], gain_z[SPK];
      longint step_w[SPK], step_x[SPK], step_y[SPK], step_z[SPK];
      bit diffuse_mode;
      logic [3:0] speaker_count;
      logic [3:0] ramp_shift;
      contribution_type expected_contribs[$];
      int errors;

      function new();
         speaker_count = 4'd8;
         ramp_shift    = 4'd6;
         diffuse_mode  = 1'b0;
         errors        = 0;
         for (int k = 0; k < SPK; k++) begin
            dir_x[k] = 0; dir_y[k] = 0; dir_z[k] = 0;
            gain_w[k] = 0; gain_x[k] = 0; gain_y[k] = 0; gain_z[k] = 0;
            step_w[k] = 0; step_x[k] = 0; step_y[k] = 0; step_z[k] = 0;
         end
      endfunction

      function void write_register(logic [nsp_pkg::CSR_INDEX_W-1:0] index,
                                   logic [3:0] value);
         if (index == nsp_pkg::CSR_SPEAKER_COUNT)
            speaker_count = value;
         else if (index == nsp_pkg::CSR_RAMP_SHIFT)
            ramp_shift = value;
      endfunction

      function int outstanding();
         return expected_contribs.size();
      endfunction

      // zero acts as one, anything past the speaker slots is clamped
      function int active_speakers();
         int n;
         n = int'(speaker_count);
         if (n < 1) n = 1;
         if (n > SPK) n = SPK;
         return n;
      endfunction

      // arithmetic shift rounds toward minus infinity
      function longint ramp_step(longint target, longint gain);
         return (target - gain) >>> ramp_shift;
      endfunction

      function longint gain_clip(longint v);
         longint lim;
         lim = longint'(1) << (GAIN_FRAC + 1);
         if (v < -lim) return -lim;
         if (v > lim - 1) return lim - 1;
         return v;
      endfunction

      function void note_accepted(panner_req_type r);
         int n, best;
         longint px, py, pz, dx, dy, dz, d, dbest, omni_target, acc, c;
         longint sw, sx, sy, sz, unit_gain;
         contribution_type e;
         n  = active_speakers();
         px = longint'(r.pos_x);
         py = longint'(r.pos_y);
         pz = longint'(r.pos_z);
         unit_gain = longint'(1) << GAIN_FRAC;
         case (r.kind)
            nsp_pkg::KIND_LOAD: begin
               dir_x[r.speaker_index] = px;
               dir_y[r.speaker_index] = py;
               dir_z[r.speaker_index] = pz;
            end
            // nearest active speaker, lowest index on ties
            nsp_pkg::KIND_POINT: begin
               best  = 0;
               dbest = 0;
               for (int k = 0; k < n; k++) begin
                  dx = px - dir_x[k];
                  dy = py - dir_y[k];
                  dz = pz - dir_z[k];
                  d  = dx * dx + dy * dy + dz * dz;
                  if (k == 0 || d < dbest) begin
                     best  = k;
                     dbest = d;
                  end
               end
               for (int k = 0; k < n; k++)
                  step_w[k] = ramp_step((k == best) ? unit_gain : longint'(0), gain_w[k]);
               diffuse_mode = 1'b0;
            end
            // omni toward 0.701, axes toward the speaker coordinates
            nsp_pkg::KIND_DIFFUSE: begin
               omni_target = (701 * unit_gain + 500) / 1000;
               for (int k = 0; k < n; k++) begin
                  step_w[k] = ramp_step(omni_target, gain_w[k]);
                  step_x[k] = ramp_step(dir_x[k] * 256, gain_x[k]);
                  step_y[k] = ramp_step(dir_y[k] * 256, gain_y[k]);
                  step_z[k] = ramp_step(dir_z[k] * 256, gain_z[k]);
               end
               diffuse_mode = 1'b1;
            end
            default: begin
               sw = longint'(r.sample_w);
               sx = longint'(r.sample_x);
               sy = longint'(r.sample_y);
               sz = longint'(r.sample_z);
               for (int k = 0; k < n; k++) begin
                  gain_w[k] = gain_clip(gain_w[k] + step_w[k]);
                  acc = gain_w[k] * sw;
                  if (diffuse_mode) begin
                     gain_x[k] = gain_clip(gain_x[k] + step_x[k]);
                     gain_y[k] = gain_clip(gain_y[k] + step_y[k]);
                     gain_z[k] = gain_clip(gain_z[k] + step_z[k]);
                     acc += gain_x[k] * sx + gain_y[k] * sy + gain_z[k] * sz;
                  end
                  c = acc >>> GAIN_FRAC;
                  if (c < -524288) c = -524288;
                  if (c > 524287) c = 524287;
                  e.speaker      = k[2:0];
                  e.contribution = c[19:0];
                  e.last         = (k + 1 == n);
                  expected_contribs = {expected_contribs, e};
               end
            end
         endcase
      endfunction

      function void check_contribution(logic [2:0] speaker, logic signed [19:0] contribution,
                                        logic last);
         contribution_type e;
         if (expected_contribs.size() == 0) begin
            $display("%0t: unexpected transfer: speaker_out %0d contribution %0d last %0b",
                     $time, speaker, contribution, last);
            errors++;
            return;
         end
         e = expected_contribs.pop_front();
         if (speaker !== e.speaker) begin
            $display("%0t: speaker_out mismatch: expected %0d, actual %0d",
                     $time, e.speaker, speaker);
            errors++;
         end
         if (contribution !== e.contribution) begin
            $display("%0t: contribution mismatch on speaker %0d: expected %0d, actual %0d",
                     $time, e.speaker, e.contribution, contribution);
            errors++;
         end
         if (last !== e.last) begin
            $display("%0t: last mismatch on speaker %0d: expected %0b, actual %0b",
                     $time, e.speaker, e.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic [1:0]                        req_kind;
   logic [2:0]                        req_speaker_index;
   logic signed [15:0]                req_pos_x, req_pos_y, req_pos_z;
   logic signed [15:0]                req_sample_w, req_sample_x, req_sample_y, req_sample_z;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic [2:0]                        rsp_speaker_out;
   logic signed [19:0]                rsp_contribution;
   logic                              rsp_last;
   logic                              csr_wr_en;
   logic [nsp_pkg::CSR_INDEX_W-1:0]   csr_index;
   logic [3:0]                        csr_wdata;

   contribution_scoreboard_type sb;
   bit quiet_phase = 1'b0;
   int items_sent  = 0;
   int cycle_count = 0;

   nearest_speaker_panner dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_speaker_index (req_speaker_index),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_pos_z         (req_pos_z),
      .req_sample_w      (req_sample_w),
      .req_sample_x      (req_sample_x),
      .req_sample_y      (req_sample_y),
      .req_sample_z      (req_sample_z),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_speaker_out   (rsp_speaker_out),
      .rsp_contribution  (rsp_contribution),
      .rsp_last          (rsp_last),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // result side: random stall bursts, none in the quiet phase
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // check every result transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_contribution(rsp_speaker_out, rsp_contribution, rsp_last);
   end

   function automatic int rand_word();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 9))
         0: return -32768;
         1: return 32767;
         2: return 0;
         default: return int'($signed(r[15:0]));
      endcase
   endfunction

   function automatic panner_req_type make_item(logic [1:0] kind, int index,
                                                int px, int py, int pz,
                                                int sw, int sx, int sy, int sz);
      panner_req_type r;
      r.kind          = kind;
      r.speaker_index = 3'(index);
      r.pos_x         = 16'(px);
      r.pos_y         = 16'(py);
      r.pos_z         = 16'(pz);
      r.sample_w      = 16'(sw);
      r.sample_x      = 16'(sx);
      r.sample_y      = 16'(sy);
      r.sample_z      = 16'(sz);
      return r;
   endfunction

   function automatic panner_req_type random_item(logic [1:0] kind);
      return make_item(kind, int'($urandom_range(0, 7)), rand_word(), rand_word(),
                       rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
   endfunction

   // one input transfer, with an optional idle burst ahead of it
   task automatic send_item(input panner_req_type r);
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_kind          <= r.kind;
      req_speaker_index <= r.speaker_index;
      req_pos_x         <= r.pos_x;
      req_pos_y         <= r.pos_y;
      req_pos_z         <= r.pos_z;
      req_sample_w      <= r.sample_w;
      req_sample_x      <= r.sample_x;
      req_sample_y      <= r.sample_y;
      req_sample_z      <= r.sample_z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_accepted(r);
      items_sent++;
   endtask

   // stop sending until every expected transfer is in, then let the block settle
   task automatic drain_results(input int settle);
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_register(input logic [nsp_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [3:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_register(index, value);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // mostly well-formed chunks: a few loads, a chunk start, then samples
   task automatic random_chunk();
      panner_req_type r;
      int loads;
      int src;
      if ($urandom_range(0, 9) == 0) begin
         send_item(random_item(2'($urandom_range(0, 3))));
         return;
      end
      loads = ($urandom_range(0, 2) == 0) ? int'($urandom_range(1, 3)) : 0;
      repeat (loads) begin
         r = random_item(nsp_pkg::KIND_LOAD);
         // copy another slot's direction now and then to force ties
         if ($urandom_range(0, 3) == 0) begin
            src     = int'($urandom_range(0, SPK - 1));
            r.pos_x = sb.dir_x[src][15:0];
            r.pos_y = sb.dir_y[src][15:0];
            r.pos_z = sb.dir_z[src][15:0];
         end
         send_item(r);
      end
      r = random_item(($urandom_range(0, 1) == 1) ? nsp_pkg::KIND_DIFFUSE
                                                    : nsp_pkg::KIND_POINT);
      if (r.kind == nsp_pkg::KIND_POINT && $urandom_range(0, 3) == 0) begin
         src     = int'($urandom_range(0, SPK - 1));
         r.pos_x = sb.dir_x[src][15:0];
         r.pos_y = sb.dir_y[src][15:0];
         r.pos_z = sb.dir_z[src][15:0];
      end
      send_item(r);
      repeat ($urandom_range(1, 5)) send_item(random_item(nsp_pkg::KIND_SAMPLE));
   endtask

   task automatic run_phase(input logic [3:0] count, input logic [3:0] shift,
                            input int n_items, input bit pause_midway);
      int start;
      drain_results(SETTLE_CYCLES);
      write_register(nsp_pkg::CSR_SPEAKER_COUNT, count);
      write_register(nsp_pkg::CSR_RAMP_SHIFT, shift);
      start = items_sent;
      while (items_sent - start < n_items) begin
         if (pause_midway && items_sent - start >= n_items / 2) begin
            drain_results(0);
            pause_midway = 1'b0;
         end
         random_chunk();
      end
   endtask

   // main sequence
   initial begin
      sb                = new();
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_kind          = nsp_pkg::KIND_SAMPLE;
      req_speaker_index = '0;
      req_pos_x         = '0;
      req_pos_y         = '0;
      req_pos_z         = '0;
      req_sample_w      = '0;
      req_sample_x      = '0;
      req_sample_y      = '0;
      req_sample_z      = '0;
      csr_wr_en         = 1'b0;
      csr_index         = nsp_pkg::CSR_SPEAKER_COUNT;
      csr_wdata         = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: sample on zero gains, then a full set of speaker directions
      send_item(make_item(nsp_pkg::KIND_SAMPLE, 0, 0, 0, 0, 32767, -32768, 32767, -32768));
      send_item(make_item(nsp_pkg::KIND_LOAD, 0, 16384, 0, 0, 0, 0, 0, 0));
      send_item(make_item(nsp_pkg::KIND_LOAD, 1, 0, 16384, 0, 0, 0, 0, 0));
      send_item(make_item(nsp_pkg::KIND_LOAD, 2, 0, 0, 16384, 0, 0, 0, 0));
      send_item(make_item(nsp_pkg::KIND_LOAD, 3, -32768, -32768, -32768, 0, 0, 0, 0));
      send_item(make_item(nsp_pkg::KIND_LOAD, 4, 32767, 32767, 32767, 0, 0, 0, 0));
      send_item(make_item(nsp_pkg::KIND_LOAD, 5, 0, 16384, 0, 0, 0, 0, 0));
      send_item(make_item(nsp_pkg::KIND_LOAD, 6, -16384, 0, 0, 0, 0, 0, 0));
      send_item(make_item(nsp_pkg::KIND_LOAD, 7, 0, 0, -16384, 0, 0, 0, 0));
      // source on speakers 1 and 5 at once: the lower index wins
      send_item(make_item(nsp_pkg::KIND_POINT, 0, 0, 16384, 0, 0, 0, 0, 0));
      send_item(make_item(nsp_pkg::KIND_SAMPLE, 0, 0, 0, 0, 32767, 32767, 32767, 32767));
      send_item(make_item(nsp_pkg::KIND_SAMPLE, 0, 0, 0, 0, -32768, 1, -1, 0));
      // diffuse mode with all four sample extremes
      send_item(make_item(nsp_pkg::KIND_DIFFUSE, 0, 0, 0, 0, 0, 0, 0, 0));
      send_item(make_item(nsp_pkg::KIND_SAMPLE, 0, 0, 0, 0, 32767, 32767, 32767, 32767));
      send_item(make_item(nsp_pkg::KIND_SAMPLE, 0, 0, 0, 0,
                          -32768, -32768, -32768, -32768));
      send_item(make_item(nsp_pkg::KIND_SAMPLE, 0, 0, 0, 0, 32767, -32768, 32767, -32768));
      // back to point mode: axis gains hold
      send_item(make_item(nsp_pkg::KIND_POINT, 0, 32767, 32767, 32767, 0, 0, 0, 0));
      send_item(make_item(nsp_pkg::KIND_SAMPLE, 0, 0, 0, 0, 32767, 32767, 32767, 32767));

      // no ramp: steps overshoot and the gains saturate
      drain_results(SETTLE_CYCLES);
      write_register(nsp_pkg::CSR_RAMP_SHIFT, 4'd0);
      send_item(make_item(nsp_pkg::KIND_POINT, 0, -32768, -32768, -32768, 0, 0, 0, 0));
      send_item(make_item(nsp_pkg::KIND_SAMPLE, 0, 0, 0, 0, 32767, 0, 0, 0));
      send_item(make_item(nsp_pkg::KIND_SAMPLE, 0, 0, 0, 0, -32768, 0, 0, 0));
      send_item(make_item(nsp_pkg::KIND_SAMPLE, 0, 0, 0, 0, 32767, 0, 0, 0));

      // random phases across the register settings
      run_phase(4'd1,  4'd0,  20, 1'b0);
      run_phase(4'd8,  4'd12, 20, 1'b1);
      run_phase(4'd0,  4'd15, 20, 1'b0);
      run_phase(4'd15, 4'd1,  20, 1'b0);
      run_phase(4'd5,  4'd2,  20, 1'b1);
      run_phase(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 20, 1'b0);
      quiet_phase = 1'b1;
      run_phase(4'd3,  4'd4,  20, 1'b0);

      drain_results(SETTLE_CYCLES);
      if (sb.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: nearest_speaker_panner.f
design/nsp_pkg.sv
design/nsp_ram.sv
design/nsp_seq.sv
design/nearest_speaker_panner.sv
verif/nearest_speaker_panner_tb.sv
